[rtl/smm_pkg.sv]
// Shared constants, codes and types of the square matrix multiply unit.
`default_nettype none

package smm_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned MAX_SIZE_DEF     = 8;
  localparam int unsigned ELEMENT_BITS_DEF = 32;

  // Fixed widths of the channel fields
  localparam int unsigned FUNC_W  = 2;
  localparam int unsigned POS_W   = 3;
  localparam int unsigned ELEM_W  = 32;
  localparam int unsigned SIZE_W  = 4;

  // Fraction bits of Q16.16 and the size register after reset
  localparam int unsigned FRAC_SHIFT = 16;
  localparam int unsigned SIZE_RESET = 8;

  // Input item function codes
  typedef enum logic [FUNC_W-1:0] {
    FUNC_WR_LEFT  = 2'd0,
    FUNC_WR_RIGHT = 2'd1,
    FUNC_START    = 2'd2
  } func_e;

  // Bookkeeping that travels with one multiply-accumulate down the pipeline
  typedef struct packed {
    logic             first;     // first term of a dot product
    logic             last_term; // final term of a dot product
    logic             last_all;  // final term of the whole product
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
  } tag_t;

endpackage

`default_nettype wire

[rtl/smm_if.sv]
// Valid/ready channel interfaces of the square matrix multiply unit.
`default_nettype none

// Input items: element writes and product starts
interface smm_in_if import smm_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [FUNC_W-1:0]        func;
  logic [POS_W-1:0]         row;
  logic [POS_W-1:0]         col;
  logic signed [ELEM_W-1:0] element;

  modport source (output valid, func, row, col, element, input ready);
  modport sink   (input valid, func, row, col, element, output ready);
endinterface

// Result items: one product element each
interface smm_out_if import smm_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic signed [ELEM_W-1:0] product_value;
  logic [POS_W-1:0]         out_row;
  logic [POS_W-1:0]         out_col;
  logic                     last;

  modport source (output valid, product_value, out_row, out_col, last, input ready);
  modport sink   (input valid, product_value, out_row, out_col, last, output ready);
endinterface

// Configuration writes of the matrix size register
interface smm_cfg_if import smm_pkg::*;;
  logic              valid;
  logic              ready;
  logic [SIZE_W-1:0] matrix_size;

  modport source (output valid, matrix_size, input ready);
  modport sink   (input valid, matrix_size, output ready);
endinterface

`default_nettype wire

[rtl/square_matrix_multiply_unit.sv]
// Top level of the square matrix multiply unit.
`default_nettype none

// Square matrix multiplier, signed fixed point with 16 fraction bits. Input
// items with func write left or right matrix elements (ignored when row or
// col is outside MAX_SIZE) or start the product of the n x n matrices, n
// taken from the matrix_size register (0 acts as 1, values above MAX_SIZE
// act as MAX_SIZE). A start emits n*n result items in row-major order, the
// last one flagged. One multiplier and one accumulator are shared by all
// terms, so each dot product sums its n terms one after another, and input
// ready stays low until the last result item has been taken. A stalled
// output holds the whole multiply-accumulate pipeline. Elements read by a
// product must have been written since reset. Configuration writes are
// taken at any time and must arrive only while the unit is idle.
module square_matrix_multiply_unit import smm_pkg::*; #(
  parameter int unsigned MAX_SIZE     = MAX_SIZE_DEF,
  parameter int unsigned ELEMENT_BITS = ELEMENT_BITS_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  smm_cfg_if.sink    cfg_i,
  smm_in_if.sink     in_i,
  smm_out_if.source  out_o
);

  localparam int unsigned EL_W   = (ELEMENT_BITS < ELEM_W) ? ELEMENT_BITS : ELEM_W;
  localparam int unsigned IDX_W  = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
  localparam int unsigned DEPTH  = MAX_SIZE * MAX_SIZE;
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned PROD_W = 2 * EL_W;
  localparam int unsigned ACC_A  = PROD_W + IDX_W + 1;
  localparam int unsigned ACC_B  = EL_W + FRAC_SHIFT + 1;
  localparam int unsigned ACC_W  = (ACC_A > ACC_B) ? ACC_A : ACC_B;
  localparam int unsigned SH_W   = ACC_W - FRAC_SHIFT;
  localparam int unsigned N_RST  = (SIZE_RESET > MAX_SIZE) ? MAX_SIZE : SIZE_RESET;
  localparam logic [IDX_W-1:0] N_M1_RST = IDX_W'(N_RST - 1);
  localparam logic [IDX_W-1:0] N_M1_MAX = IDX_W'(MAX_SIZE - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } state_e;

  state_e            state_q;
  logic [IDX_W-1:0]  n_m1_q;
  logic [IDX_W-1:0]  i_q, k_q, j_q;
  logic              v1_q, v2_q, acc_done_q, out_valid_q;
  tag_t              tag1_q, tag2_q, tag3_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q;

  logic              stall, adv, load_out, in_acc;
  logic              wr_ok, wr_left, wr_right;
  logic              run_issue, final_issue;
  logic              j_end, k_end, i_end;
  logic [IDX_W-1:0]  row_idx, col_idx;
  logic [ADDR_W-1:0] wr_addr, left_raddr, right_raddr, left_addr, right_addr;
  logic signed [EL_W-1:0]  left_rd, right_rd, wr_elem;
  logic signed [ACC_W-1:0] prod_ext;
  logic [SH_W-1:0]         shifted;
  logic signed [EL_W-1:0]  sat_val;
  logic                    ovf;

  // Configuration: clamp the size on write, keep n-1
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_m1_q <= N_M1_RST;
    end else if (cfg_i.valid) begin
      if (cfg_i.matrix_size == '0) begin
        n_m1_q <= '0;
      end else if (cfg_i.matrix_size > MAX_SIZE) begin
        n_m1_q <= N_M1_MAX;
      end else begin
        n_m1_q <= IDX_W'(cfg_i.matrix_size - 1'b1);
      end
    end
  end

  // Input handshake and element write decode
  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign row_idx    = in_i.row[IDX_W-1:0];
  assign col_idx    = in_i.col[IDX_W-1:0];
  assign wr_ok      = in_acc && (in_i.row < MAX_SIZE) && (in_i.col < MAX_SIZE);
  assign wr_left    = wr_ok && (in_i.func == FUNC_WR_LEFT);
  assign wr_right   = wr_ok && (in_i.func == FUNC_WR_RIGHT);
  assign wr_elem    = in_i.element[EL_W-1:0];
  assign wr_addr    = ADDR_W'(row_idx * MAX_SIZE + col_idx);

  // Read addresses of the current term: left (i,j), right (j,k)
  assign left_raddr  = ADDR_W'(i_q * MAX_SIZE + j_q);
  assign right_raddr = ADDR_W'(j_q * MAX_SIZE + k_q);
  assign left_addr   = (state_q == ST_IDLE) ? wr_addr : left_raddr;
  assign right_addr  = (state_q == ST_IDLE) ? wr_addr : right_raddr;

  // Output slot: load a finished sum when empty or being drained
  assign load_out = acc_done_q && (!out_valid_q || out_o.ready);
  assign stall    = acc_done_q && !load_out;
  assign adv      = !stall;

  // Term counters
  assign j_end       = (j_q == n_m1_q);
  assign k_end       = (k_q == n_m1_q);
  assign i_end       = (i_q == n_m1_q);
  assign run_issue   = (state_q == ST_RUN) && adv;
  assign final_issue = j_end && k_end && i_end;

  smm_ram #(
    .WIDTH (EL_W),
    .DEPTH (DEPTH)
  ) u_left_ram (
    .clk_i   (clk_i),
    .we_i    (wr_left),
    .re_i    (adv),
    .addr_i  (left_addr),
    .wdata_i (wr_elem),
    .rdata_o (left_rd)
  );

  smm_ram #(
    .WIDTH (EL_W),
    .DEPTH (DEPTH)
  ) u_right_ram (
    .clk_i   (clk_i),
    .we_i    (wr_right),
    .re_i    (adv),
    .addr_i  (right_addr),
    .wdata_i (wr_elem),
    .rdata_o (right_rd)
  );

  // Sequencer: state, term counters, stage valids and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      i_q         <= '0;
      k_q         <= '0;
      j_q         <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      acc_done_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc && (in_i.func == FUNC_START)) begin
            i_q     <= '0;
            k_q     <= '0;
            j_q     <= '0;
            state_q <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (adv) begin
            if (j_end) begin
              j_q <= '0;
              if (k_end) begin
                k_q <= '0;
                i_q <= i_q + 1'b1;
              end else begin
                k_q <= k_q + 1'b1;
              end
            end else begin
              j_q <= j_q + 1'b1;
            end
            if (final_issue) begin
              state_q <= ST_DRAIN;
            end
          end
        end
        ST_DRAIN: begin
          if (out_valid_q && out_o.ready && out_o.last) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase

      // Advance stage valids unless the output blocks
      if (adv) begin
        v1_q       <= run_issue;
        v2_q       <= v1_q;
        acc_done_q <= v2_q && tag2_q.last_term;
      end

      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Accumulator operand and final scaling with saturation
  assign prod_ext = ACC_W'(prod_q);
  assign shifted  = acc_q[ACC_W-1:FRAC_SHIFT];
  assign ovf      = !((&shifted[SH_W-1:EL_W-1]) || !(|shifted[SH_W-1:EL_W-1]));

  always_comb begin
    if (!ovf) begin
      sat_val = shifted[EL_W-1:0];
    end else if (shifted[SH_W-1]) begin
      sat_val = {1'b1, {(EL_W-1){1'b0}}};
    end else begin
      sat_val = {1'b0, {(EL_W-1){1'b1}}};
    end
  end

  // Pipeline payload: tags, product, accumulator, output item
  always_ff @(posedge clk_i) begin
    if (adv) begin
      tag1_q.first     <= (j_q == '0);
      tag1_q.last_term <= j_end;
      tag1_q.last_all  <= final_issue;
      tag1_q.row       <= POS_W'(i_q);
      tag1_q.col       <= POS_W'(k_q);
      tag2_q           <= tag1_q;
      prod_q           <= left_rd * right_rd;
      tag3_q           <= tag2_q;
      if (v2_q) begin
        acc_q <= tag2_q.first ? prod_ext : acc_q + prod_ext;
      end
    end
    if (load_out) begin
      out_o.product_value <= ELEM_W'(sat_val);
      out_o.out_row       <= tag3_q.row;
      out_o.out_col       <= tag3_q.col;
      out_o.last          <= tag3_q.last_all;
    end
  end

  assign out_o.valid = out_valid_q;

`ifndef SYNTH
  // Idle means nothing in flight and no pending result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !v1_q && !v2_q && !acc_done_q && !out_valid_q)
    else $error("smm: work in flight while idle");

  // A blocked output freezes the running sum
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall |=> $stable(acc_q) && acc_done_q)
    else $error("smm: accumulator moved during stall");

  // The final result item only shows while draining
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_o.last) |-> (state_q == ST_DRAIN))
    else $error("smm: last item outside drain");
`endif

endmodule

`default_nettype wire

[rtl/smm_ram.sv]
// Generic single-port RAM with registered read data.
`default_nettype none

module smm_ram #(
  parameter int unsigned WIDTH  = 32,
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] addr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write on we, register read data on re
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[addr_i];
    end
  end

endmodule

`default_nettype wire

[bench/tb_top.sv]
// Self-checking testbench of the square matrix multiply unit.
`timescale 1ns / 1ps

module tb_top;
  import smm_pkg::*;

  localparam int unsigned STRIDE       = MAX_SIZE_DEF;
  localparam int unsigned DEPTH        = MAX_SIZE_DEF * MAX_SIZE_DEF;
  localparam int unsigned RANDOM_ITEMS = 30;
  localparam int unsigned IDLE_PCT     = 36;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned TAIL_CYCLES  = 40;
  localparam int unsigned CYCLE_LIMIT  = 400000;

  // Unused function code, ignored by the block
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  localparam logic signed [127:0] SAT_HI = 128'sd2147483647;
  localparam logic signed [127:0] SAT_LO = -128'sd2147483648;

  typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_e;

  // One row of the directed table; for ROW_CFG the element holds the size
  typedef struct {
    row_kind_e         kind;
    logic [FUNC_W-1:0] func;
    logic [POS_W-1:0]  row;
    logic [POS_W-1:0]  col;
    logic [ELEM_W-1:0] element;
    logic              lit_on;
    logic [ELEM_W-1:0] lit_value;
  } stim_row_t;

  typedef struct packed {
    logic [ELEM_W-1:0] value;
    logic [POS_W-1:0]  row;
    logic [POS_W-1:0]  col;
    logic              last;
  } product_elem_t;

  logic clk;
  logic rst_n;

  smm_cfg_if cfg_if ();
  smm_in_if  in_if ();
  smm_out_if out_if ();

  square_matrix_multiply_unit dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Predictor state: both element stores, written flags, size register
  logic signed [ELEM_W-1:0] left_mem  [DEPTH];
  logic signed [ELEM_W-1:0] right_mem [DEPTH];
  bit                       left_seen [DEPTH];
  bit                       right_seen[DEPTH];
  logic [SIZE_W-1:0]        size_reg;

  product_elem_t product_q[$];
  stim_row_t     stim_q[$];
  product_elem_t got_elem;
  product_elem_t want_elem;

  bit          calm;
  int unsigned fail_count;
  int unsigned item_count;
  int unsigned product_count;
  int unsigned result_count;
  int unsigned cycle_count;
  bit [15:0]   sizes_used;

  // Clock
  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending",
               cycle_count, product_q.size());
      $display("square_matrix_multiply_unit regression: fail");
      $finish;
    end
  end

  function automatic int unsigned eff_size(input logic [SIZE_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_SIZE_DEF) return MAX_SIZE_DEF;
    return v;
  endfunction

  // Exact dot product of left row i and right column k, floor shift, saturate
  function automatic logic [ELEM_W-1:0] dot_value(input int unsigned i, k, n);
    logic signed [127:0] acc;
    logic signed [63:0]  term;
    logic signed [127:0] shifted;
    acc = '0;
    for (int unsigned j = 0; j < n; j++) begin
      term = left_mem[i * STRIDE + j] * right_mem[j * STRIDE + k];
      acc  = acc + term;
    end
    shifted = acc >>> FRAC_SHIFT;
    if (shifted > SAT_HI) return 32'h7FFF_FFFF;
    if (shifted < SAT_LO) return 32'h8000_0000;
    return shifted[ELEM_W-1:0];
  endfunction

  // Update the stores or queue the products of one accepted item
  task automatic apply_item(input logic [FUNC_W-1:0] f, input logic [POS_W-1:0] r, c,
                            input logic [ELEM_W-1:0] e);
    int unsigned   n;
    product_elem_t pe;
    case (f)
      FUNC_WR_LEFT: begin
        left_mem[r * STRIDE + c]  = e;
        left_seen[r * STRIDE + c] = 1'b1;
      end
      FUNC_WR_RIGHT: begin
        right_mem[r * STRIDE + c]  = e;
        right_seen[r * STRIDE + c] = 1'b1;
      end
      FUNC_START: begin
        n = eff_size(size_reg);
        for (int unsigned i = 0; i < n; i++) begin
          for (int unsigned k = 0; k < n; k++) begin
            pe.value = dot_value(i, k, n);
            pe.row   = i[POS_W-1:0];
            pe.col   = k[POS_W-1:0];
            pe.last  = (i == n - 1) && (k == n - 1);
            product_q.push_back(pe);
          end
        end
        product_count++;
        sizes_used[size_reg] = 1'b1;
      end
      default: ;
    endcase
  endtask

  // Drive one item, idling at random first, and hold it until taken
  task automatic push_item(input logic [FUNC_W-1:0] f, input logic [POS_W-1:0] r, c,
                           input logic [ELEM_W-1:0] e);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.func    <= f;
    in_if.row     <= r;
    in_if.col     <= c;
    in_if.element <= e;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    apply_item(f, r, c, e);
    if (f != FUNC_UNUSED) item_count++;
  endtask

  // Mostly small Q16.16 values, some full-range and some extremes
  function automatic logic [ELEM_W-1:0] rand_element();
    logic [ELEM_W-1:0] v;
    case ($urandom_range(0, 7))
      0, 1:    v = $urandom;
      2: begin
        case ($urandom_range(0, 2))
          0:       v = 32'h7FFF_FFFF;
          1:       v = 32'h8000_0000;
          default: v = '0;
        endcase
      end
      default: v = $urandom_range(0, 524288) - 262144;
    endcase
    return v;
  endfunction

  // Write every element the next product reads that was never written, then start
  task automatic issue_start();
    int unsigned       n;
    logic [POS_W-1:0]  r;
    logic [POS_W-1:0]  c;
    n = eff_size(size_reg);
    for (int unsigned i = 0; i < n; i++) begin
      for (int unsigned j = 0; j < n; j++) begin
        r = i[POS_W-1:0];
        c = j[POS_W-1:0];
        if (!left_seen[i * STRIDE + j]) push_item(FUNC_WR_LEFT, r, c, rand_element());
        if (!right_seen[i * STRIDE + j]) push_item(FUNC_WR_RIGHT, r, c, rand_element());
      end
    end
    r = $urandom;
    c = $urandom;
    push_item(FUNC_START, r, c, $urandom);
  endtask

  // Write the size register once the block has drained
  task automatic set_size(input logic [SIZE_W-1:0] v);
    in_if.valid <= 1'b0;
    while (product_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_if.valid       <= 1'b1;
    cfg_if.matrix_size <= v;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    size_reg = v;
  endtask

  task automatic add_row(input row_kind_e kind, input logic [FUNC_W-1:0] f,
                         input logic [POS_W-1:0] r, c, input logic [ELEM_W-1:0] e,
                         input logic lit_on, input logic [ELEM_W-1:0] lit);
    stim_row_t sr;
    sr.kind      = kind;
    sr.func      = f;
    sr.row       = r;
    sr.col       = c;
    sr.element   = e;
    sr.lit_on    = lit_on;
    sr.lit_value = lit;
    stim_q.push_back(sr);
  endtask

  // Output side: stall at random, check each taken result against the oldest
  always @(posedge clk) begin
    if (rst_n) begin
      out_if.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      if (out_if.valid && out_if.ready) begin
        result_count <= result_count + 1;
        got_elem.value = out_if.product_value;
        got_elem.row   = out_if.out_row;
        got_elem.col   = out_if.out_col;
        got_elem.last  = out_if.last;
        if (product_q.size() == 0) begin
          $error("result item with none expected: value %h row %0d col %0d last %0d",
                 got_elem.value, got_elem.row, got_elem.col, got_elem.last);
          fail_count++;
        end else begin
          want_elem = product_q.pop_front();
          if (got_elem.value !== want_elem.value) begin
            $error("product_value: expected %h, got %h", want_elem.value, got_elem.value);
            fail_count++;
          end
          if (got_elem.row !== want_elem.row) begin
            $error("out_row: expected %0d, got %0d", want_elem.row, got_elem.row);
            fail_count++;
          end
          if (got_elem.col !== want_elem.col) begin
            $error("out_col: expected %0d, got %0d", want_elem.col, got_elem.col);
            fail_count++;
          end
          if (got_elem.last !== want_elem.last) begin
            $error("last: expected %0d, got %0d", want_elem.last, got_elem.last);
            fail_count++;
          end
        end
      end
    end
  end

  // Stimulus
  initial begin
    stim_row_t         sr;
    product_elem_t     pe;
    int unsigned       directed_items;
    int unsigned       phase;
    int unsigned       n;
    int unsigned       n_wr;
    logic [SIZE_W-1:0] sz;
    logic [POS_W-1:0]  r;
    logic [POS_W-1:0]  c;
    logic [FUNC_W-1:0] f;

    cfg_if.valid       = 1'b0;
    cfg_if.matrix_size = '0;
    in_if.valid        = 1'b0;
    in_if.func         = '0;
    in_if.row          = '0;
    in_if.col          = '0;
    in_if.element      = '0;
    out_if.ready       = 1'b0;
    calm               = 1'b0;
    fail_count         = 0;
    item_count         = 0;
    product_count      = 0;
    result_count       = 0;
    cycle_count        = 0;
    sizes_used         = '0;
    size_reg           = SIZE_RESET;
    for (int i = 0; i < DEPTH; i++) begin
      left_mem[i]   = '0;
      right_mem[i]  = '0;
      left_seen[i]  = 1'b0;
      right_seen[i] = 1'b0;
    end

    // Reset
    rst_n = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table: 1x1 products read at a glance, then larger sizes
    add_row(ROW_CFG,  FUNC_WR_LEFT,  0, 0, 32'd1,        0, '0);
    add_row(ROW_ITEM, FUNC_WR_LEFT,  0, 0, 32'h0001_0000, 0, '0);
    add_row(ROW_ITEM, FUNC_WR_RIGHT, 0, 0, 32'h0002_0000, 0, '0);
    add_row(ROW_ITEM, FUNC_START,    0, 0, '0,           1, 32'h0002_0000);
    add_row(ROW_ITEM, FUNC_WR_LEFT,  0, 0, 32'h7FFF_FFFF, 0, '0);
    add_row(ROW_ITEM, FUNC_WR_RIGHT, 0, 0, 32'h7FFF_FFFF, 0, '0);
    add_row(ROW_ITEM, FUNC_START,    7, 7, 32'hFFFF_FFFF, 1, 32'h7FFF_FFFF);
    add_row(ROW_ITEM, FUNC_WR_RIGHT, 0, 0, 32'h8000_0000, 0, '0);
    add_row(ROW_ITEM, FUNC_START,    0, 0, '0,           1, 32'h8000_0000);
    add_row(ROW_ITEM, FUNC_WR_LEFT,  0, 0, 32'h8000_0000, 0, '0);
    add_row(ROW_ITEM, FUNC_START,    0, 0, '0,           1, 32'h7FFF_FFFF);
    // Smallest negative product floors to minus one LSB
    add_row(ROW_ITEM, FUNC_WR_LEFT,  0, 0, 32'hFFFF_FFFF, 0, '0);
    add_row(ROW_ITEM, FUNC_WR_RIGHT, 0, 0, 32'h0000_0001, 0, '0);
    add_row(ROW_ITEM, FUNC_START,    0, 0, '0,           1, 32'hFFFF_FFFF);
    // Unused function code changes nothing
    add_row(ROW_ITEM, FUNC_UNUSED,   0, 0, 32'h1234_5678, 0, '0);
    add_row(ROW_ITEM, FUNC_UNUSED,   7, 7, 32'hFFFF_FFFF, 0, '0);
    // Size zero acts as one
    add_row(ROW_CFG,  FUNC_WR_LEFT,  0, 0, 32'd0,        0, '0);
    add_row(ROW_ITEM, FUNC_START,    0, 0, '0,           1, 32'hFFFF_FFFF);
    add_row(ROW_ITEM, FUNC_WR_LEFT,  7, 7, 32'h0003_8000, 0, '0);
    add_row(ROW_CFG,  FUNC_WR_LEFT,  0, 0, 32'd2,        0, '0);
    add_row(ROW_ITEM, FUNC_WR_LEFT,  0, 1, 32'hFFFE_0000, 0, '0);
    add_row(ROW_ITEM, FUNC_WR_RIGHT, 1, 0, 32'h0000_8000, 0, '0);
    add_row(ROW_ITEM, FUNC_START,    0, 0, '0,           0, '0);
    // Sizes above the maximum act as the maximum
    add_row(ROW_CFG,  FUNC_WR_LEFT,  0, 0, 32'd15,       0, '0);
    add_row(ROW_ITEM, FUNC_START,    0, 0, '0,           0, '0);
    add_row(ROW_CFG,  FUNC_WR_LEFT,  0, 0, 32'd8,        0, '0);
    add_row(ROW_ITEM, FUNC_START,    0, 0, '0,           0, '0);

    foreach (stim_q[idx]) begin
      sr = stim_q[idx];
      if (sr.kind == ROW_CFG) begin
        set_size(sr.element[SIZE_W-1:0]);
      end else if (sr.func == FUNC_START) begin
        issue_start();
        if (sr.lit_on) begin
          pe       = product_q.pop_back();
          pe.value = sr.lit_value;
          product_q.push_back(pe);
        end
      end else begin
        push_item(sr.func, sr.row, sr.col, sr.element);
      end
    end
    directed_items = item_count;

    // Random phases: pick a size, then in one to three rounds load some elements and start one or two products
    phase = 0;
    while (item_count < directed_items + RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       sz = 4'd0;
        1:       sz = 4'd15;
        2:       sz = 4'd8;
        3:       sz = $urandom_range(9, 14);
        default: sz = $urandom_range(1, 4);
      endcase
      set_size(sz);
      calm = (phase == 0);
      n = eff_size(sz);
      repeat ($urandom_range(1, 3)) begin
        if (item_count >= directed_items + RANDOM_ITEMS) break;
        n_wr = $urandom_range(0, n + 2);
        repeat (n_wr) begin
          if ($urandom_range(9) < 8) begin
            r = $urandom_range(0, n - 1);
            c = $urandom_range(0, n - 1);
          end else begin
            r = $urandom;
            c = $urandom;
          end
          if ($urandom_range(9) == 0) f = FUNC_UNUSED;
          else if ($urandom_range(1) == 0) f = FUNC_WR_LEFT;
          else f = FUNC_WR_RIGHT;
          push_item(f, r, c, rand_element());
        end
        issue_start();
        if ($urandom_range(3) == 0) issue_start();
      end
      phase++;
    end
    calm = 1'b0;
    in_if.valid <= 1'b0;

    // Drain, then watch for stray results
    while (product_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("ran %0d input items, %0d products, %0d result items in %0d cycles",
             item_count, product_count, result_count, cycle_count);
    $display("size register settings started with: %b (bit per value 15..0)", sizes_used);
    if (fail_count == 0 && product_q.size() == 0) begin
      $display("square_matrix_multiply_unit regression: pass");
    end else begin
      $display("square_matrix_multiply_unit regression: fail");
    end
    $finish;
  end

endmodule

[files.f]
rtl/smm_pkg.sv
rtl/smm_if.sv
rtl/smm_ram.sv
rtl/square_matrix_multiply_unit.sv
bench/tb_top.sv
